// ===== src/ptt_pkg.sv =====
package ptt_pkg;

	// Coordinate width of every input field
	localparam int COORD_WIDTH = 16;

	// Number of coordinate fields in one query
	localparam int NUM_COORDS = 8;

	// Stream widths
	localparam int IN_TDATA_W  = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = 8;

	// Internal arithmetic widths, exact for any coordinate width
	localparam int DIFF_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int CMP_W   = CROSS_W + 2;

	// Field positions inside s_tdata
	localparam int F_POINT_X  = 0;
	localparam int F_POINT_Y  = 1;
	localparam int F_FIRST_X  = 2;
	localparam int F_FIRST_Y  = 3;
	localparam int F_SECOND_X = 4;
	localparam int F_SECOND_Y = 5;
	localparam int F_THIRD_X  = 6;
	localparam int F_THIRD_Y  = 7;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		logic signed [DIFF_W-1:0] e0x;
		logic signed [DIFF_W-1:0] e0y;
		logic signed [DIFF_W-1:0] e1x;
		logic signed [DIFF_W-1:0] e1y;
		logic signed [DIFF_W-1:0] qx;
		logic signed [DIFF_W-1:0] qy;
	} diff_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] c_pos;
		logic signed [PROD_W-1:0] c_neg;
		logic signed [PROD_W-1:0] a_pos;
		logic signed [PROD_W-1:0] a_neg;
		logic signed [PROD_W-1:0] b_pos;
		logic signed [PROD_W-1:0] b_neg;
	} prod_t;

	typedef struct packed {
		logic signed [CROSS_W-1:0] a;
		logic signed [CROSS_W-1:0] b;
		logic signed [CROSS_W-1:0] c;
	} cross_t;

	typedef struct packed {
		logic inside_res;
		logic degenerate;
	} result_t;

endpackage

// ===== src/ptt_edge.sv =====
module ptt_edge (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [ptt_pkg::IN_TDATA_W-1:0]  in_data,
	output logic                            valid_s1,
	output ptt_pkg::diff_t                  diff_s1
);
	import ptt_pkg::*;

	coord_t px, py, fx, fy, sx, sy, tx, ty;
	diff_t  diff_d;

	assign px = coord_t'(in_data[F_POINT_X  * COORD_WIDTH +: COORD_WIDTH]);
	assign py = coord_t'(in_data[F_POINT_Y  * COORD_WIDTH +: COORD_WIDTH]);
	assign fx = coord_t'(in_data[F_FIRST_X  * COORD_WIDTH +: COORD_WIDTH]);
	assign fy = coord_t'(in_data[F_FIRST_Y  * COORD_WIDTH +: COORD_WIDTH]);
	assign sx = coord_t'(in_data[F_SECOND_X * COORD_WIDTH +: COORD_WIDTH]);
	assign sy = coord_t'(in_data[F_SECOND_Y * COORD_WIDTH +: COORD_WIDTH]);
	assign tx = coord_t'(in_data[F_THIRD_X  * COORD_WIDTH +: COORD_WIDTH]);
	assign ty = coord_t'(in_data[F_THIRD_Y  * COORD_WIDTH +: COORD_WIDTH]);

	// Edge vectors and point offset, all from the first vertex
	always_comb begin
		diff_d.e0x = DIFF_W'(tx) - DIFF_W'(fx);
		diff_d.e0y = DIFF_W'(ty) - DIFF_W'(fy);
		diff_d.e1x = DIFF_W'(sx) - DIFF_W'(fx);
		diff_d.e1y = DIFF_W'(sy) - DIFF_W'(fy);
		diff_d.qx  = DIFF_W'(px) - DIFF_W'(fx);
		diff_d.qy  = DIFF_W'(py) - DIFF_W'(fy);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= diff_d;
		end
	end

endmodule

// ===== src/ptt_mul.sv =====
module ptt_mul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_s1,
	input  ptt_pkg::diff_t  diff_s1,
	output logic            valid_s2,
	output ptt_pkg::prod_t  prod_s2
);
	import ptt_pkg::*;

	prod_t prod_d;

	// Six independent products, one multiplier each
	always_comb begin
		prod_d.c_pos = PROD_W'(diff_s1.e0x) * PROD_W'(diff_s1.e1y);
		prod_d.c_neg = PROD_W'(diff_s1.e0y) * PROD_W'(diff_s1.e1x);
		prod_d.a_pos = PROD_W'(diff_s1.qx)  * PROD_W'(diff_s1.e1y);
		prod_d.a_neg = PROD_W'(diff_s1.qy)  * PROD_W'(diff_s1.e1x);
		prod_d.b_pos = PROD_W'(diff_s1.e0x) * PROD_W'(diff_s1.qy);
		prod_d.b_neg = PROD_W'(diff_s1.e0y) * PROD_W'(diff_s1.qx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod_d;
		end
	end

endmodule

// ===== src/ptt_cross.sv =====
module ptt_cross (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_s2,
	input  ptt_pkg::prod_t  prod_s2,
	output logic            valid_s4,
	output ptt_pkg::cross_t norm_s4,
	output logic            degen_s4
);
	import ptt_pkg::*;

	logic   valid_s3;
	cross_t cross_s3;
	cross_t cross_d;
	cross_t norm_d;

	// Cross products from the product pairs
	always_comb begin
		cross_d.c = CROSS_W'(prod_s2.c_pos) - CROSS_W'(prod_s2.c_neg);
		cross_d.a = CROSS_W'(prod_s2.a_pos) - CROSS_W'(prod_s2.a_neg);
		cross_d.b = CROSS_W'(prod_s2.b_pos) - CROSS_W'(prod_s2.b_neg);
	end

	// Flip all three signs when the winding is negative
	always_comb begin
		if (cross_s3.c[CROSS_W-1]) begin
			norm_d.c = -cross_s3.c;
			norm_d.a = -cross_s3.a;
			norm_d.b = -cross_s3.b;
		end else begin
			norm_d = cross_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cross_s3 <= cross_d;
			norm_s4  <= norm_d;
			degen_s4 <= (cross_s3.c == '0);
		end
	end

endmodule

// ===== src/ptt_decide.sv =====
module ptt_decide (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              valid_s4,
	input  ptt_pkg::cross_t   norm_s4,
	input  logic              degen_s4,
	output logic              valid_s5,
	output ptt_pkg::result_t  res_s5
);
	import ptt_pkg::*;

	logic signed [CMP_W-1:0] a_w, b_w, c_w;
	logic signed [CMP_W-1:0] c_minus_a, c_minus_b, c_minus_ab;
	logic                    inside_d;

	assign a_w = CMP_W'(norm_s4.a);
	assign b_w = CMP_W'(norm_s4.b);
	assign c_w = CMP_W'(norm_s4.c);

	assign c_minus_a  = c_w - a_w;
	assign c_minus_b  = c_w - b_w;
	assign c_minus_ab = c_w - a_w - b_w;

	// Boundaries count as inside; a zero-area triangle never does
	assign inside_d = !degen_s4
		&& !a_w[CMP_W-1] && !b_w[CMP_W-1]
		&& !c_minus_a[CMP_W-1] && !c_minus_b[CMP_W-1]
		&& !c_minus_ab[CMP_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5.inside_res <= inside_d;
			res_s5.degenerate <= degen_s4;
		end
	end

endmodule

// ===== src/point_in_triangle_test.sv =====
// Throughput: one query per cycle while no stall on m_tready holds the pipeline;
// the five register stages (edges, products, cross products, sign fold, compare)
// each take a new query every cycle when not stalled, and a query passes them in order.
// A stall on m_tready freezes every stage at once; nothing is dropped.
// Reset (arst_n low, asynchronous) clears all stage valid bits; data is not reset.
module point_in_triangle_test (
	input  logic                              clk,
	input  logic                              arst_n,
	// s_tdata, from bit 0 up: point_x, point_y, first_x, first_y,
	// second_x, second_y, third_x, third_y (COORD_WIDTH bits each)
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ptt_pkg::IN_TDATA_W-1:0]    s_tdata,
	// m_tdata, from bit 0 up: inside_res, then zero fill
	// m_tuser: degenerate
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ptt_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tuser
);
	import ptt_pkg::*;

	logic    en;
	logic    valid_s1, valid_s2, valid_s4, valid_s5;
	diff_t   diff_s1;
	prod_t   prod_s2;
	cross_t  norm_s4;
	logic    degen_s4;
	result_t res_s5;

	// Advance the whole pipeline whenever the output register is free or
	// its result is being taken this cycle; otherwise hold every stage.
	assign en       = !valid_s5 || m_tready;
	assign s_tready = en;

	// Stage 1: edge vectors e0 = third - first, e1 = second - first, and
	// offset q = point - first
	ptt_edge u_edge (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.valid_s1 (valid_s1),
		.diff_s1  (diff_s1)
	);

	// Stage 2: the six cross-product terms
	ptt_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.diff_s1  (diff_s1),
		.valid_s2 (valid_s2),
		.prod_s2  (prod_s2)
	);

	// Stages 3 and 4: c, a, b, then fold the sign of c into all three and
	// flag a zero-area triangle
	ptt_cross u_cross (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s2 (valid_s2),
		.prod_s2  (prod_s2),
		.valid_s4 (valid_s4),
		.norm_s4  (norm_s4),
		.degen_s4 (degen_s4)
	);

	// Stage 5: range compares of a, b and a + b against c; this is also the
	// output register
	ptt_decide u_decide (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s4 (valid_s4),
		.norm_s4  (norm_s4),
		.degen_s4 (degen_s4),
		.valid_s5 (valid_s5),
		.res_s5   (res_s5)
	);

	assign m_tvalid = valid_s5;
	assign m_tdata  = {{(OUT_TDATA_W-1){1'b0}}, res_s5.inside_res};
	assign m_tuser  = res_s5.degenerate;

	// A zero-area triangle never reports inside
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tuser))
		else $error("degenerate result marked inside");

	// A query in the sign-fold stage reaches the output on the next advance
	assert property (@(posedge clk) disable iff (!arst_n)
		(en && valid_s4) |=> m_tvalid)
		else $error("stage 4 item lost");

	// While stalled, no stage may move: the first and fourth stages hold their valid bits
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> (valid_s1 == $past(valid_s1)) && (valid_s4 == $past(valid_s4)))
		else $error("pipeline moved during stall");

	// An input transfer fills stage 1 on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted query not captured");

endmodule
